>>> hdl/q2e_pkg.sv
// Shared constants and the CORDIC arctangent table for the quaternion to Euler converter.
package q2e_pkg;

  // Angle accumulator: pi is 2^31, headroom for the pre-rotation and stage sums.
  localparam int ZW = 34;
  localparam logic signed [ZW-1:0] HALF_TURN = 34'sh0_8000_0000;

  // Pitch path: cosine root has 31 bits (30 fraction bits, up to 1.0).
  localparam int SQRT_BITS = 31;
  localparam int RAD_W = 2 * SQRT_BITS;
  localparam int PITCH_IW = SQRT_BITS + 1;

  // atan(2^-i) with pi = 2^31, rounded.
  function automatic logic [31:0] atan_const(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h20000000;
      1: v = 32'h12E4051E;
      2: v = 32'h09FB385B;
      3: v = 32'h051111D4;
      4: v = 32'h028B0D43;
      5: v = 32'h0145D7E1;
      6: v = 32'h00A2F61E;
      7: v = 32'h00517C55;
      8: v = 32'h0028BE53;
      9: v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/q2e_quat_if.sv
// Channel interfaces: quaternion in, Euler angles out.
interface q2e_quat_if #(
  parameter int CW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] q_w;
  logic signed [CW-1:0] q_x;
  logic signed [CW-1:0] q_y;
  logic signed [CW-1:0] q_z;

  modport source (output valid, q_w, q_x, q_y, q_z, input ready);
  modport sink (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

interface q2e_euler_if #(
  parameter int AW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [AW-1:0] yaw_angle;
  logic signed [AW-1:0] pitch_angle;
  logic signed [AW-1:0] roll_angle;
  logic                 pitch_clamped;

  modport source (output valid, yaw_angle, pitch_angle, roll_angle, pitch_clamped,
                  input ready);
  modport sink (input valid, yaw_angle, pitch_angle, roll_angle, pitch_clamped,
                output ready);
endinterface

>>> hdl/quaternion_to_euler_angles.sv
// Quaternion to yaw, pitch and roll converter: products, sums, square root and CORDIC cells.
// Throughput: one quaternion per cycle; the whole pipeline holds while the output stalls.
// The pipeline's length is set by the pitch path: 31 square-root cells feeding the pitch CORDIC chain.
// Reset (rst, synchronous) clears the valid bits only; no state outlives a transaction.
module quaternion_to_euler_angles #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int ANGLE_WIDTH     = 16,
  parameter int CORDIC_STAGES   = 16
) (
  input logic         clk,
  input logic         rst,
  q2e_quat_if.sink    quat,
  q2e_euler_if.source euler
);
  import q2e_pkg::*;

  localparam int CW    = COMPONENT_WIDTH;
  localparam int AW    = ANGLE_WIDTH;
  // Products keep all fraction bits up to 28-bit components, then drop to 56 bits.
  localparam int PS    = (CW > 28) ? (2 * CW - 56) : 0;
  localparam int PW    = 2 * CW - PS;
  localparam int SW    = PW + 2;
  localparam int SCALE = PW - 4;
  localparam int K     = SCALE - 30;
  // Stage numbering: products 1, sums 2, pitch argument 3, square 4, radicand 5.
  localparam int LAT   = SQRT_BITS + 7 + CORDIC_STAGES;

  localparam logic signed [SW-1:0] ONE = SW'(1) << SCALE;
  localparam logic signed [AW-1:0] QTR = AW'(1) << (AW - 2);

  logic en;
  logic [LAT:1] vld;

  // Advance everything unless the output holds a transaction not yet taken.
  assign en         = !vld[LAT] || euler.ready;
  assign quat.ready = en;
  assign euler.valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], quat.valid};
    end
  end

  // ---- Stage 1: the nine component products ----
  logic signed [2*CW-1:0] m_wz, m_xy, m_yy, m_zz, m_wx, m_yz, m_xx, m_wy, m_zx;
  logic signed [PW-1:0]   p_wz, p_xy, p_yy, p_zz, p_wx, p_yz, p_xx, p_wy, p_zx;

  always_comb begin
    m_wz = quat.q_w * quat.q_z;
    m_xy = quat.q_x * quat.q_y;
    m_yy = quat.q_y * quat.q_y;
    m_zz = quat.q_z * quat.q_z;
    m_wx = quat.q_w * quat.q_x;
    m_yz = quat.q_y * quat.q_z;
    m_xx = quat.q_x * quat.q_x;
    m_wy = quat.q_w * quat.q_y;
    m_zx = quat.q_z * quat.q_x;
  end

  // Floor shift to the common scale.
  always_ff @(posedge clk) begin
    if (en) begin
      p_wz <= m_wz[2*CW-1:PS];
      p_xy <= m_xy[2*CW-1:PS];
      p_yy <= m_yy[2*CW-1:PS];
      p_zz <= m_zz[2*CW-1:PS];
      p_wx <= m_wx[2*CW-1:PS];
      p_yz <= m_yz[2*CW-1:PS];
      p_xx <= m_xx[2*CW-1:PS];
      p_wy <= m_wy[2*CW-1:PS];
      p_zx <= m_zx[2*CW-1:PS];
    end
  end

  // ---- Stage 2: numerators, denominators and the pitch argument ----
  logic signed [SW-1:0] s_ny, s_dy, s_nr, s_dr, s_arg;
  logic signed [SW-1:0] ny, dy, nr, dr, arg;

  always_comb begin
    s_ny  = SW'(p_wz) + SW'(p_xy);
    s_dy  = SW'(p_yy) + SW'(p_zz);
    s_nr  = SW'(p_wx) + SW'(p_yz);
    s_dr  = SW'(p_xx) + SW'(p_yy);
    s_arg = SW'(p_wy) - SW'(p_zx);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ny  <= s_ny <<< 1;
      dy  <= ONE - (s_dy <<< 1);
      nr  <= s_nr <<< 1;
      dr  <= ONE - (s_dr <<< 1);
      arg <= s_arg <<< 1;
    end
  end

  // ---- Stage 3: gimbal-lock test, argument at 30 fraction bits ----
  logic signed [63:0] arg64;
  logic signed [63:0] a64;
  logic signed [30:0] a_c;
  logic signed [30:0] a_abs;
  logic signed [30:0] a_r;
  logic [29:0]        mag_r;
  logic               lock_r;
  logic               neg_r;

  assign arg64 = 64'(arg);

  if (K >= 0) begin : g_shr
    assign a64 = arg64 >>> K;
  end else begin : g_shl
    assign a64 = arg64 <<< (-K);
  end

  assign a_c   = a64[30:0];
  assign a_abs = a_c[30] ? -a_c : a_c;

  always_ff @(posedge clk) begin
    if (en) begin
      lock_r <= (arg >= ONE) || (arg <= -ONE);
      neg_r  <= arg[SW-1];
      a_r    <= a_c;
      mag_r  <= a_abs[29:0];
    end
  end

  // ---- Stages 4 and 5: radicand 2^60 - a^2 ----
  logic [59:0]      sq;
  logic [RAD_W-1:0] rad;

  always_ff @(posedge clk) begin
    if (en) begin
      sq  <= 60'(mag_r) * 60'(mag_r);
      rad <= RAD_W'(61'h1000_0000_0000_0000) - RAD_W'(sq);
    end
  end

  // ---- Square-root chain: one root bit per cell, most significant first ----
  logic [RAD_W-1:0]     rem_s  [SQRT_BITS+1];
  logic [SQRT_BITS-1:0] root_s [SQRT_BITS+1];

  assign rem_s[0]  = rad;
  assign root_s[0] = '0;

  for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
    q2e_sqrt_cell #(
      .BIT (SQRT_BITS - 1 - j)
    ) u_sqrt (
      .clk      (clk),
      .en       (en),
      .rem_in   (rem_s[j]),
      .root_in  (root_s[j]),
      .rem_out  (rem_s[j+1]),
      .root_out (root_s[j+1])
    );
  end

  // Align the sine with the cosine root.
  logic [30:0] a_dly;

  q2e_delay #(
    .W     (31),
    .DEPTH (SQRT_BITS + 2)
  ) u_a_dly (
    .clk  (clk),
    .en   (en),
    .din  (a_r),
    .dout (a_dly)
  );

  // ---- CORDIC chains ----
  logic signed [AW-1:0] yaw_c, roll_c, pitch_c;

  q2e_cordic #(
    .IW     (SW),
    .AW     (AW),
    .STAGES (CORDIC_STAGES)
  ) u_yaw (
    .clk   (clk),
    .en    (en),
    .y_in  (ny),
    .x_in  (dy),
    .angle (yaw_c)
  );

  q2e_cordic #(
    .IW     (SW),
    .AW     (AW),
    .STAGES (CORDIC_STAGES)
  ) u_roll (
    .clk   (clk),
    .en    (en),
    .y_in  (nr),
    .x_in  (dr),
    .angle (roll_c)
  );

  q2e_cordic #(
    .IW     (PITCH_IW),
    .AW     (AW),
    .STAGES (CORDIC_STAGES)
  ) u_pitch (
    .clk   (clk),
    .en    (en),
    .y_in  (PITCH_IW'(signed'(a_dly))),
    .x_in  (signed'({1'b0, root_s[SQRT_BITS]})),
    .angle (pitch_c)
  );

  // Hold yaw and roll until pitch catches up.
  logic [2*AW-1:0] yr_dly;

  q2e_delay #(
    .W     (2 * AW),
    .DEPTH (SQRT_BITS + 3)
  ) u_yr_dly (
    .clk  (clk),
    .en   (en),
    .din  ({yaw_c, roll_c}),
    .dout (yr_dly)
  );

  // Carry the lock flag and argument sign to the output stage.
  logic [1:0] lock_dly;

  q2e_delay #(
    .W     (2),
    .DEPTH (LAT - 3)
  ) u_lock_dly (
    .clk  (clk),
    .en   (en),
    .din  ({lock_r, neg_r}),
    .dout (lock_dly)
  );

  assign euler.yaw_angle     = yr_dly[2*AW-1:AW];
  assign euler.roll_angle    = yr_dly[AW-1:0];
  assign euler.pitch_clamped = lock_dly[1];
  // Gimbal lock: replace pitch by a quarter turn with the argument's sign.
  assign euler.pitch_angle   = lock_dly[1] ? (lock_dly[0] ? -QTR : QTR) : pitch_c;

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (quat.valid && quat.ready) |=> vld[1])
    else $error("accepted transaction did not enter the pipeline");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (euler.valid && !euler.ready) |-> (!quat.ready ##1 $stable(vld)))
    else $error("pipeline moved while output stalled");

  a_lock_pitch: assert property (@(posedge clk) disable iff (rst)
    (euler.valid && euler.pitch_clamped) |->
      (euler.pitch_angle == QTR || euler.pitch_angle == -QTR))
    else $error("clamped pitch is not a quarter turn");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !euler.valid)
    else $error("output valid after reset");
`endif
endmodule

>>> hdl/q2e_delay.sv
// Enabled shift line that aligns side data with the long pipeline paths.
module q2e_delay #(
  parameter int W     = 16,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);
  logic [W-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];
endmodule

>>> hdl/q2e_sqrt_cell.sv
// One restoring square-root cell: decide one root bit, hand remainder on.
module q2e_sqrt_cell #(
  parameter int BIT = 30
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [q2e_pkg::RAD_W-1:0]      rem_in,
  input  logic [q2e_pkg::SQRT_BITS-1:0]  root_in,
  output logic [q2e_pkg::RAD_W-1:0]      rem_out,
  output logic [q2e_pkg::SQRT_BITS-1:0]  root_out
);
  import q2e_pkg::*;

  logic [RAD_W-1:0] trial;

  // (R + 2^b)^2 - R^2 = R*2^(b+1) + 2^(2b)
  assign trial = (RAD_W'(root_in) << (BIT + 1)) + (RAD_W'(1) << (2 * BIT));

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_in >= trial) begin
        rem_out  <= rem_in - trial;
        root_out <= root_in | (SQRT_BITS'(1) << BIT);
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in;
      end
    end
  end
endmodule

>>> hdl/q2e_cordic_cell.sv
// One vectoring CORDIC micro-rotation; a held vector passes through untouched.
module q2e_cordic_cell #(
  parameter int XW    = 18,
  parameter int STAGE = 0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [XW-1:0]           x_in,
  input  logic signed [XW-1:0]           y_in,
  input  logic signed [q2e_pkg::ZW-1:0]  z_in,
  input  logic                           hold_in,
  output logic signed [XW-1:0]           x_out,
  output logic signed [XW-1:0]           y_out,
  output logic signed [q2e_pkg::ZW-1:0]  z_out,
  output logic                           hold_out
);
  import q2e_pkg::*;

  localparam logic signed [ZW-1:0] ANG = ZW'(atan_const(STAGE));

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  assign dx = y_in >>> STAGE;
  assign dy = x_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (en) begin
      hold_out <= hold_in;
      if (hold_in) begin
        x_out <= x_in;
        y_out <= y_in;
        z_out <= z_in;
      end else if (!y_in[XW-1]) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ANG;
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ANG;
      end
    end
  end
endmodule

>>> hdl/q2e_cordic.sv
// atan2 pipeline: half-plane pre-rotation, a chain of CORDIC cells, rounding to angle units.
module q2e_cordic #(
  parameter int IW     = 34,
  parameter int AW     = 16,
  parameter int STAGES = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [IW-1:0] y_in,
  input  logic signed [IW-1:0] x_in,
  output logic signed [AW-1:0] angle
);
  import q2e_pkg::*;

  localparam int XW = IW + 2;
  localparam int SH = 32 - AW;

  logic signed [XW-1:0] xs [STAGES+1];
  logic signed [XW-1:0] ys [STAGES+1];
  logic signed [ZW-1:0] zs [STAGES+1];
  logic                 hs [STAGES+1];

  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] y_ext;

  logic signed [XW-1:0] x_pre;
  logic signed [XW-1:0] y_pre;
  logic signed [ZW-1:0] z_pre;
  logic                 h_pre;

  assign x_ext = XW'(x_in);
  assign y_ext = XW'(y_in);

  // Zero numerator finishes at once; left half-plane flips and starts at +/-pi.
  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in == '0) begin
        h_pre <= 1'b1;
        x_pre <= x_ext;
        y_pre <= y_ext;
        z_pre <= x_in[IW-1] ? HALF_TURN : '0;
      end else if (x_in[IW-1]) begin
        h_pre <= 1'b0;
        x_pre <= -x_ext;
        y_pre <= -y_ext;
        z_pre <= y_in[IW-1] ? -HALF_TURN : HALF_TURN;
      end else begin
        h_pre <= 1'b0;
        x_pre <= x_ext;
        y_pre <= y_ext;
        z_pre <= '0;
      end
    end
  end

  assign xs[0] = x_pre;
  assign ys[0] = y_pre;
  assign zs[0] = z_pre;
  assign hs[0] = h_pre;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    q2e_cordic_cell #(
      .XW    (XW),
      .STAGE (i)
    ) u_cell (
      .clk      (clk),
      .en       (en),
      .x_in     (xs[i]),
      .y_in     (ys[i]),
      .z_in     (zs[i]),
      .hold_in  (hs[i]),
      .x_out    (xs[i+1]),
      .y_out    (ys[i+1]),
      .z_out    (zs[i+1]),
      .hold_out (hs[i+1])
    );
  end

  // Round half up to AW bits when bits are dropped; +pi wraps to -pi.
  if (SH > 0) begin : g_round
    logic signed [ZW-1:0] z_rnd;
    assign z_rnd = zs[STAGES] + (ZW'(1) << (SH - 1));
    always_ff @(posedge clk) begin
      if (en) begin
        angle <= z_rnd[SH+AW-1:SH];
      end
    end
  end else begin : g_exact
    always_ff @(posedge clk) begin
      if (en) begin
        angle <= zs[STAGES][AW-1:0];
      end
    end
  end
endmodule

>>> test/quaternion_to_euler_angles_tb.sv
// Self-checking testbench for the quaternion to yaw, pitch and roll converter.
module quaternion_to_euler_angles_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;
  localparam int AW = 16;
  localparam int STAGES = 16;
  localparam int FRAC = CW - 2;
  localparam int SCALE = 2 * FRAC;
  localparam int LATENCY = STAGES + 38;

  typedef struct packed {
    logic signed [AW-1:0] yaw;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] roll;
    logic                 clamped;
  } euler_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  q2e_quat_if #(.CW(CW)) quat ();
  q2e_euler_if #(.AW(AW)) euler ();

  quaternion_to_euler_angles #(
    .COMPONENT_WIDTH(CW),
    .ANGLE_WIDTH(AW),
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .quat(quat.sink),
    .euler(euler.source)
  );

  euler_t angles_due[$];
  int     error_count = 0;
  int     send_idle_pct = 0;   // chance in percent that the sender skips a cycle
  int     recv_idle_pct = 0;   // chance in percent that the receiver stalls
  bit     hold_off = 1'b0;     // long receiver stall for back-pressure

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: fixed-point vectoring CORDIC, pi = 2^31 in the accumulator.
  // ---------------------------------------------------------------------------

  // Own table of atan(2^-i) with pi = 2^31.
  function automatic longint q2e_pkg_atan(int i);
    longint tab[16] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
    return tab[i];
  endfunction

  function automatic longint cordic_angle(longint y, longint x);
    longint acc;
    longint dx;
    longint dy;
    acc = 0;
    if (y == 0) return (x < 0) ? 64'sd2147483648 : 64'sd0;
    // pre-rotate the left half plane by a half turn
    if (x < 0) begin
      acc = (y > 0) ? 64'sd2147483648 : -64'sd2147483648;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; acc += longint'(q2e_pkg_atan(i));
      end else begin
        x -= dx; y += dy; acc -= longint'(q2e_pkg_atan(i));
      end
    end
    return acc;
  endfunction

  // Round half up from 32 to AW bits, then wrap.
  function automatic logic [AW-1:0] binary_angle(longint acc);
    longint r;
    r = (acc + (64'sd1 <<< (32 - AW - 1))) >>> (32 - AW);
    return r[AW-1:0];
  endfunction

  function automatic longint int_sqrt(longint unsigned d);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > d) b >>= 2;
    while (b != 0) begin
      if (d >= res + b) begin
        d -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic euler_t predict_angles(logic signed [CW-1:0] qw, logic signed [CW-1:0] qx,
                                            logic signed [CW-1:0] qy,
                                            logic signed [CW-1:0] qz);
    longint w, x, y, z, unity, ny, dy, nr, dr, sine, a, c;
    longint unsigned mag;
    euler_t e;
    w = qw; x = qx; y = qy; z = qz;
    unity = 64'sd1 <<< SCALE;
    ny = 2 * (w * z + x * y);
    dy = unity - 2 * (y * y + z * z);
    nr = 2 * (w * x + y * z);
    dr = unity - 2 * (x * x + y * y);
    sine = 2 * (w * y - z * x);
    if (sine >= unity || sine <= -unity) begin
      // gimbal lock: clamp to a quarter turn with the sign of the argument
      e.pitch = (sine > 0) ? (AW'(1) <<< (AW - 2)) : -(AW'(1) <<< (AW - 2));
      e.clamped = 1'b1;
    end else begin
      a = sine <<< (30 - SCALE);
      mag = (a < 0) ? -a : a;
      c = int_sqrt((64'd1 << 60) - mag * mag);
      e.pitch = binary_angle(cordic_angle(a, c));
      e.clamped = 1'b0;
    end
    e.yaw = binary_angle(cordic_angle(ny, dy));
    e.roll = binary_angle(cordic_angle(nr, dr));
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer one quaternion, hold it until the transaction completes.
  // ---------------------------------------------------------------------------
  task automatic send_quat(logic [CW-1:0] w, logic [CW-1:0] x, logic [CW-1:0] y,
                           logic [CW-1:0] z);
    // random idle cycles before the offer
    while ($urandom_range(99) < send_idle_pct) begin
      quat.valid <= 1'b0;
      @(posedge clk);
    end
    quat.valid <= 1'b1;
    quat.q_w <= w;
    quat.q_x <= x;
    quat.q_y <= y;
    quat.q_z <= z;
    angles_due.push_back(predict_angles(w, x, y, z));
    @(posedge clk);
    while (!quat.ready) @(posedge clk);
  endtask

  // Drop valid once the last transaction of a phase is through.
  task automatic end_burst();
    quat.valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when asked.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      euler.ready <= 1'b0;
    end else begin
      euler.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Checker: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    euler_t exp_e;
    if (!rst && euler.valid && euler.ready) begin
      if (angles_due.size() == 0) begin
        $error("unexpected result: yaw %0d pitch %0d roll %0d",
               euler.yaw_angle, euler.pitch_angle, euler.roll_angle);
        error_count++;
      end else begin
        exp_e = angles_due.pop_front();
        if (euler.yaw_angle !== exp_e.yaw) begin
          $error("yaw_angle: expected %0d, got %0d", exp_e.yaw, euler.yaw_angle);
          error_count++;
        end
        if (euler.pitch_angle !== exp_e.pitch) begin
          $error("pitch_angle: expected %0d, got %0d", exp_e.pitch, euler.pitch_angle);
          error_count++;
        end
        if (euler.roll_angle !== exp_e.roll) begin
          $error("roll_angle: expected %0d, got %0d", exp_e.roll, euler.roll_angle);
          error_count++;
        end
        if (euler.pitch_clamped !== exp_e.clamped) begin
          $error("pitch_clamped: expected %0b, got %0b", exp_e.clamped,
                 euler.pitch_clamped);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  localparam logic [CW-1:0] ONE = 16'sd16384;
  localparam logic [CW-1:0] HALF = 16'sd8192;

  // Extremes, identity, zero, and the gimbal-lock cases on both signs.
  task automatic test_directed();
    send_quat('0, '0, '0, '0);               // zero quaternion
    send_quat(ONE, '0, '0, '0);              // identity
    send_quat(-ONE, '0, '0, '0);
    send_quat('0, ONE, '0, '0);              // half turn about x: roll at pi
    send_quat('0, '0, ONE, '0);
    send_quat('0, '0, '0, ONE);              // yaw half turn
    send_quat(HALF, HALF, HALF, HALF);       // pitch argument exactly zero
    send_quat(HALF, -HALF, HALF, HALF);      // pitch argument exactly +1
    send_quat(HALF, HALF, -HALF, HALF);      // pitch argument exactly -1
    send_quat(16'sd11585, '0, 16'sd11585, '0); // just under +1
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001);
    send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    send_quat(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    send_quat('0, ONE, '0, '0);
    end_burst();
  endtask

  // Mostly components within +/-1.0, some raw noise over the full field range, some gimbal lock.
  task automatic test_random(int count);
    logic [CW-1:0] c[4];
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(3) == 0) c[k] = CW'($urandom);
        else c[k] = 16'($signed($urandom_range(2 * 16384)) - 16384);
      end
      if ($urandom_range(19) == 0) begin
        // land on gimbal lock with random sign and small perturbation
        c[0] = HALF; c[1] = -HALF; c[2] = HALF;
        c[3] = HALF + CW'($urandom_range(2));
        if ($urandom_range(1)) begin
          c[1] = HALF; c[2] = -HALF;
        end
      end
      send_quat(c[0], c[1], c[2], c[3]);
    end
    end_burst();
  endtask

  // Hold the receiver off long enough for the pipeline to fill and stall input.
  task automatic test_back_pressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (3 * LATENCY) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(150);
    join
  endtask

  task automatic wait_drained();
    while (angles_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    quat.valid = 1'b0;
    quat.q_w = '0;
    quat.q_x = '0;
    quat.q_y = '0;
    quat.q_z = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    send_idle_pct = 24; recv_idle_pct = 80;
    test_random(400);
    send_idle_pct = 80; recv_idle_pct = 24;
    test_random(400);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_back_pressure();
    test_random(250);
    wait_drained();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
